// File: hw/rtl/hdtm_pkg.sv
// Shared types, constants and codes of the header dynamic table manager.
package hdtm_pkg;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int DATA_RING_BYTES_DEF = 4096;
  localparam int TABLE_SIZE_LIMIT_DEF = 4096;
  localparam int ENTRY_OVERHEAD_DEF = 32;
  localparam int RECORD_HEADER_BYTES_DEF = 6;
  localparam int STATIC_COUNT_DEF = 61;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SET_MAX = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] name_len;
    logic [12:0] value_len;
    logic [15:0] new_max;
    logic [7:0]  table_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        evicted_all;
    logic [5:0]  slot;
    logic        static_hit;
    logic [5:0]  static_index;
    logic [11:0] data_offset;
    logic [12:0] entry_name_len;
    logic [12:0] entry_value_len;
    logic [5:0]  entry_count;
    logic [12:0] used_bytes;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic evict;     // retire the oldest entry and emit a notice
    logic finish;    // commit the operation and emit the completion
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_evict; // table too full for the operation in hand
    logic empty;
    logic incons;     // byte head does not match the oldest record
    logic out_busy;   // output register holds an untaken result
  } sts_t;
endpackage

// File: hw/rtl/hdtm_ram.sv
// Generic single write port RAM with a registered read port.
module hdtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// File: hw/rtl/hdtm_ctrl.sv
// Controller state machine of the header dynamic table manager.
module hdtm_ctrl import hdtm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  sts_t       sts,
  output logic       in_stall,
  output cmd_t       cmd
);
  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_EVICT, S_FINISH} state_t;
  state_t state_r, state_nxt;
  logic [1:0] func_r, func_nxt;

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          func_nxt = in_func;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // The slot stores are read here; their data is ready in the next state.
        if (func_r == FUNC_LOOKUP) begin
          state_nxt = S_FINISH;
        end else if ((func_r == FUNC_ADD || func_r == FUNC_SET_MAX) &&
                     sts.need_evict && !sts.empty) begin
          state_nxt = S_EVICT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_EVICT: begin
        if (sts.incons) begin
          state_nxt = S_FINISH;
        end else if (!sts.out_busy) begin
          cmd.evict = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      func_r <= FUNC_ADD;
    end else begin
      state_r <= state_nxt;
      func_r <= func_nxt;
    end
  end

  a_evict_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.evict && cmd.finish)) else $error("evict and finish together");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && state_r != S_IDLE)) else $error("load outside idle");
  a_incons_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT && $past(state_r) == S_EVICT) |-> $stable(sts.incons))
    else $error("inconsistency flag changed in evict");
endmodule

// File: hw/rtl/hdtm_dp.sv
// Datapath of the header dynamic table manager: pointers, slot stores, result register.
module hdtm_dp import hdtm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DATA_RING_BYTES = DATA_RING_BYTES_DEF,
  parameter int TABLE_SIZE_LIMIT = TABLE_SIZE_LIMIT_DEF,
  parameter int ENTRY_OVERHEAD = ENTRY_OVERHEAD_DEF,
  parameter int RECORD_HEADER_BYTES = RECORD_HEADER_BYTES_DEF,
  parameter int STATIC_COUNT = STATIC_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  input  logic      out_stall,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_data
);
  localparam int SW = $clog2(MAX_ENTRIES);
  localparam int BW = $clog2(DATA_RING_BYTES);
  localparam int MW = $clog2(TABLE_SIZE_LIMIT + 1);
  localparam int CW = $clog2(MAX_ENTRIES);

  in_item_t item_r;
  logic [SW-1:0] oldest_r, next_r;
  logic [BW-1:0] head_r, tail_r;
  logic [CW-1:0] live_r;
  logic [MW-1:0] acc_r, max_r;
  logic out_valid_r;
  out_item_t out_r;

  logic [SW-1:0] raddr;
  logic [BW-1:0] rd_off;
  logic [12:0] rd_nl, rd_vl;
  logic we;

  // Sums in 17 bits cover name and value lengths and the overhead.
  logic [16:0] size, rec, need, ring_used, free_b, cost;
  logic add_ok, need_evict;
  logic [8:0] idx_lim;

  assign size = 17'(item_r.name_len) + 17'(item_r.value_len) + 17'(ENTRY_OVERHEAD);
  assign rec = 17'(item_r.name_len) + 17'(item_r.value_len) + 17'(RECORD_HEADER_BYTES);
  assign need = size + 17'(acc_r);
  assign cost = 17'(rd_nl) + 17'(rd_vl) + 17'(ENTRY_OVERHEAD);

  always_comb begin
    logic [BW-1:0] d;
    d = tail_r - head_r;
    if (live_r == '0) ring_used = '0;
    else if (d == '0) ring_used = 17'(DATA_RING_BYTES);
    else ring_used = 17'(d);
  end
  assign free_b = 17'(DATA_RING_BYTES) - ring_used;

  always_comb begin
    case (item_r.func)
      FUNC_ADD: need_evict = (size <= 17'(max_r)) && (need > 17'(max_r));
      FUNC_SET_MAX: need_evict = (item_r.new_max != '0) &&
                                 (17'(item_r.new_max) <= 17'(TABLE_SIZE_LIMIT)) &&
                                 (17'(item_r.new_max) < 17'(acc_r));
      default: need_evict = 1'b0;
    endcase
  end

  assign sts.need_evict = need_evict;
  assign sts.empty = (live_r == '0);
  assign sts.incons = (head_r != rd_off);
  assign sts.out_busy = out_valid_r && out_stall;

  assign add_ok = !(sts.incons && need_evict) && (32'(live_r) < MAX_ENTRIES - 1) &&
                  (rec <= free_b);
  assign idx_lim = 9'(live_r) + 9'(STATIC_COUNT);

  logic [SW-1:0] lk_slot;
  assign lk_slot = next_r - SW'(item_r.table_index);
  // A lookup keeps its slot addressed, so the read data survives a stalled completion.
  assign raddr = (item_r.func == FUNC_LOOKUP) ? lk_slot : oldest_r;
  assign we = cmd.finish && item_r.func == FUNC_ADD && size <= 17'(max_r) && add_ok;

  hdtm_ram #(.WIDTH(BW), .DEPTH(MAX_ENTRIES)) u_off (
    .clk(clk), .we(we), .waddr(next_r), .wdata(tail_r), .raddr(raddr), .rdata(rd_off));
  hdtm_ram #(.WIDTH(13), .DEPTH(MAX_ENTRIES)) u_nl (
    .clk(clk), .we(we), .waddr(next_r), .wdata(item_r.name_len), .raddr(raddr),
    .rdata(rd_nl));
  hdtm_ram #(.WIDTH(13), .DEPTH(MAX_ENTRIES)) u_vl (
    .clk(clk), .we(we), .waddr(next_r), .wdata(item_r.value_len), .raddr(raddr),
    .rdata(rd_vl));

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0; next_r <= '0; head_r <= '0; tail_r <= '0;
      live_r <= '0; acc_r <= '0; max_r <= MW'(TABLE_SIZE_LIMIT);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.evict || cmd.finish) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.evict) begin : evt
        out_item_t note;
        note = '0;
        note.slot = 6'(oldest_r);
        note.data_offset = 12'(rd_off);
        note.entry_name_len = rd_nl;
        note.entry_value_len = rd_vl;
        note.entry_count = 6'(live_r - 1'b1);
        note.used_bytes = (17'(acc_r) > cost) ? 13'(17'(acc_r) - cost) : '0;
        out_r <= note;
        head_r <= BW'(17'(head_r) + 17'(RECORD_HEADER_BYTES) + 17'(rd_nl) + 17'(rd_vl));
        oldest_r <= oldest_r + 1'b1;
        live_r <= live_r - 1'b1;
        acc_r <= (17'(acc_r) > cost) ? MW'(17'(acc_r) - cost) : '0;
      end
      if (cmd.finish) begin : fin
        out_item_t r;
        logic [SW-1:0] cnt_n;
        logic [MW-1:0] acc_n;
        r = '0;
        r.result_kind = 1'b1;
        r.last = 1'b1;
        cnt_n = live_r;
        acc_n = acc_r;
        case (item_r.func)
          FUNC_ADD: begin
            if (size > 17'(max_r)) begin
              r.evicted_all = 1'b1;
              oldest_r <= '0; next_r <= '0; head_r <= '0; tail_r <= '0;
              cnt_n = '0; acc_n = '0;
            end else if (!add_ok || (need_evict && live_r != '0)) begin
              r.status = ST_ERROR;
            end else begin
              r.slot = 6'(next_r);
              r.data_offset = 12'(tail_r);
              r.entry_name_len = item_r.name_len;
              r.entry_value_len = item_r.value_len;
              tail_r <= BW'(17'(tail_r) + rec);
              next_r <= next_r + 1'b1;
              cnt_n = live_r + 1'b1;
              acc_n = MW'(need);
            end
          end
          FUNC_SET_MAX: begin
            if (17'(item_r.new_max) > 17'(TABLE_SIZE_LIMIT)) begin
              r.status = ST_ERROR;
            end else if (item_r.new_max == '0) begin
              oldest_r <= '0; next_r <= '0; head_r <= '0; tail_r <= '0;
              cnt_n = '0; acc_n = '0; max_r <= '0;
            end else if (need_evict && live_r != '0) begin
              r.status = ST_ERROR;
            end else begin
              max_r <= MW'(item_r.new_max);
            end
          end
          FUNC_LOOKUP: begin
            if (item_r.table_index == '0) begin
              r.status = ST_ERROR;
            end else if (9'(item_r.table_index) > idx_lim) begin
              r.status = ST_NOT_FOUND;
            end else if (9'(item_r.table_index) > 9'(live_r)) begin
              r.static_hit = 1'b1;
              r.static_index = 6'(9'(item_r.table_index) - 9'(live_r) - 9'd1);
            end else begin
              r.slot = 6'(lk_slot);
              r.data_offset = 12'(BW'(17'(rd_off) + 17'(RECORD_HEADER_BYTES)));
              r.entry_name_len = rd_nl;
              r.entry_value_len = rd_vl;
            end
          end
          default: begin
            oldest_r <= '0; next_r <= '0; head_r <= '0; tail_r <= '0;
            cnt_n = '0; acc_n = '0;
          end
        endcase
        r.entry_count = 6'(cnt_n);
        r.used_bytes = 13'(acc_n);
        live_r <= cnt_n;
        acc_r <= acc_n;
        out_r <= r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_r) < MAX_ENTRIES) else $error("live count overflow");
  a_evict_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.evict && live_r == '0)) else $error("evict from empty table");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && out_stall && (cmd.evict || cmd.finish)))
    else $error("result overwritten while stalled");
endmodule

// File: hw/rtl/header_dynamic_table_manager.sv
// Top level of the header dynamic table manager.
// Each accepted item yields zero or more eviction notices, then one completion with last set.
// An item without evictions goes through the check and finish states to its completion; every
// eviction adds the evict and check states, as the controller walks the slot ring one entry
// at a time through the registered read of the slot stores. One item is in work at a time;
// input stalls until the completion has been loaded into the output register.
module header_dynamic_table_manager import hdtm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DATA_RING_BYTES = DATA_RING_BYTES_DEF,
  parameter int TABLE_SIZE_LIMIT = TABLE_SIZE_LIMIT_DEF,
  parameter int ENTRY_OVERHEAD = ENTRY_OVERHEAD_DEF,
  parameter int RECORD_HEADER_BYTES = RECORD_HEADER_BYTES_DEF,
  parameter int STATIC_COUNT = STATIC_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  cmd_t cmd;
  sts_t sts;

  hdtm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_func(in_data.func),
    .sts(sts), .in_stall(in_stall), .cmd(cmd));

  hdtm_dp #(
    .MAX_ENTRIES(MAX_ENTRIES), .DATA_RING_BYTES(DATA_RING_BYTES),
    .TABLE_SIZE_LIMIT(TABLE_SIZE_LIMIT), .ENTRY_OVERHEAD(ENTRY_OVERHEAD),
    .RECORD_HEADER_BYTES(RECORD_HEADER_BYTES), .STATIC_COUNT(STATIC_COUNT)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .out_stall(out_stall),
    .sts(sts), .out_valid(out_valid), .out_data(out_data));
endmodule
